### src/ets_pkg.sv
// Shared types and character constants for the expression token scanner.
`default_nettype none

package ets_pkg;

    typedef logic [7:0] char_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_INT  = 3'd1,
        PH_FRAC = 3'd2,
        PH_EXP  = 3'd3,
        PH_EXPD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NUMBER   = 2'd0,
        KIND_VARIABLE = 2'd1,
        KIND_OPERATOR = 2'd2
    } kind_t;

    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_NL    = 8'h0A;
    localparam char_t CH_DOT   = 8'h2E;
    localparam char_t CH_E     = 8'h65;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_LC_A  = 8'h61;
    localparam char_t CH_LC_Z  = 8'h7A;

    // Scan result for the word held in the input stage.
    typedef struct packed {
        logic  emit;
        kind_t kind;
        logic  start;
    } scan_res_t;

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input char_t c);
        return (c == CH_SPACE) || (c == CH_NL);
    endfunction

endpackage

`default_nettype wire

### src/expression_token_scanner.sv
// Top level of the expression token scanner: input stage, scan core, result register.
`default_nettype none

// Scans one character word per cycle unless a result is blocked under out_stall:
// a word sits in the input register, is classified against the number phase register
// in the same cycle it moves on, and lands in the result register. The phase register
// loop sets the rate at one word per cycle; spaces and newlines are dropped and give
// no result. A result held under out_stall does not block the input stage until that
// stage also holds a word that produces a result.
module expression_token_scanner
    import ets_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [7:0] char_in,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] char_out,
    output logic [1:0] token_kind,
    output logic       token_start
);

    logic      s1_valid;
    char_t     s1_char;
    scan_res_t res;
    logic      advance;
    logic      out_free;

    logic      out_valid_reg;
    logic      out_valid_next;
    char_t     out_char_reg;
    kind_t     out_kind_reg;
    logic      out_start_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid && (!res.emit || out_free);

    ets_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .char_in  (char_in),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_char  (s1_char)
    );

    ets_scan_core u_scan_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .c       (s1_char),
        .res     (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            out_char_reg  <= s1_char;
            out_kind_reg  <= res.kind;
            out_start_reg <= res.start;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = out_char_reg;
    assign token_kind  = out_kind_reg;
    assign token_start = out_start_reg;

`ifndef NO_ASSERTIONS
    a_no_space_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_out != CH_SPACE) && (char_out != CH_NL))
        else $error("whitespace word reached the result register");

    a_single_char_token: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == KIND_VARIABLE || token_kind == KIND_OPERATOR)
        |-> token_start)
        else $error("variable or operator word without token start");

    a_variable_letter: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_VARIABLE
        |-> (char_out >= CH_LC_A) && (char_out <= CH_LC_Z))
        else $error("variable kind on a non-letter word");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid && res.emit && out_valid && out_stall)
        else $error("input stalled without a blocked result");

    a_number_start_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_NUMBER && token_start
        |-> (char_out >= CH_ZERO) && (char_out <= CH_NINE))
        else $error("number token started on a non-digit");
`endif

endmodule

`default_nettype wire

### src/ets_in_stage.sv
// Input register stage: holds one word until the scan core moves it on.
`default_nettype none

module ets_in_stage
    import ets_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   in_valid,
    output logic  in_stall,
    input  char_t char_in,
    input  wire   advance,
    output logic  s1_valid,
    output char_t s1_char
);

    logic  s1_valid_reg;
    logic  s1_valid_next;
    char_t s1_char_reg;
    logic  load;

    assign in_stall = s1_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_char_reg <= char_in;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_char  = s1_char_reg;

endmodule

`default_nettype wire

### src/ets_scan_core.sv
// Scan core: number phase register and per-character classification.
`default_nettype none

module ets_scan_core
    import ets_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       advance,
    input  char_t     c,
    output scan_res_t res
);

    phase_t phase_reg;
    phase_t phase_next;
    phase_t ext;
    logic   dig;

    assign dig = is_digit(c);

    // Phase after c if c extends the current number, else idle.
    always_comb
    begin
        ext = PH_IDLE;
        case (phase_reg)
            PH_INT:
            begin
                if (dig)               ext = PH_INT;
                else if (c == CH_DOT)  ext = PH_FRAC;
                else if (c == CH_E)    ext = PH_EXP;
            end
            PH_FRAC:
            begin
                if (dig)               ext = PH_FRAC;
                else if (c == CH_E)    ext = PH_EXP;
            end
            PH_EXP:
            begin
                if (dig || c == CH_PLUS || c == CH_MINUS) ext = PH_EXPD;
            end
            PH_EXPD:
            begin
                if (dig)               ext = PH_EXPD;
            end
            default:
            begin
                ext = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.emit   = 1'b1;
        res.kind   = KIND_NUMBER;
        res.start  = 1'b0;
        phase_next = ext;
        if (is_space(c))
        begin
            res.emit   = 1'b0;
            phase_next = PH_IDLE;
        end
        else if (ext == PH_IDLE)
        begin
            // Scan afresh as the first character of a new token.
            res.start = 1'b1;
            if (dig)
            begin
                phase_next = PH_INT;
            end
            else if (c >= CH_LC_A && c <= CH_LC_Z)
            begin
                res.kind = KIND_VARIABLE;
            end
            else
            begin
                res.kind = KIND_OPERATOR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire
